>>> rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros used by the port checker.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define NLP_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// Next-cycle implication.
`define NLP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

>>> rtl/core/nlp_pkg.sv
// ----------------------------------------------------------------------------
// nlp_pkg
// Types, constants and codes of the note length parser.
// ----------------------------------------------------------------------------
`default_nettype none

package nlp_pkg;

    localparam int TICKS_PER_WHOLE = 96;
    localparam int DIV_W_RAW       = $clog2(TICKS_PER_WHOLE + 1);
    localparam int DIV_W           = (DIV_W_RAW < 2) ? 2 : DIV_W_RAW;
    localparam int CNT_W           = $clog2(DIV_W + 1);
    localparam int VAL_W           = 15;

    localparam logic [VAL_W-1:0] SAT_MAX = '1;

    localparam logic [7:0] CH_PCT   = 8'h25;
    localparam logic [7:0] CH_CARET = 8'h5E;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;

    typedef struct packed {
        logic [7:0]       ch;
        logic             first;
        logic [VAL_W-1:0] default_clocks;
    } nlp_in_t;

    typedef struct packed {
        logic               consumed;
        logic               done_res;
        logic signed [15:0] length;
        logic               relative;
        logic               found;
    } nlp_out_t;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_PART_START,
        PH_PART_DIGITS,
        PH_DOTS,
        PH_TRAIL,
        PH_PCT_SIGN,
        PH_PCT_DIGITS
    } phase_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EVAL,
        S_DIV
    } seq_t;

    typedef enum logic [1:0] {
        LEN_ZERO,
        LEN_TOTAL,
        LEN_DEFAULT
    } len_sel_t;

    typedef struct packed {
        logic     load;
        logic     acc_start;
        logic     acc_digit;
        logic     part_default;
        logic     div_start;
        logic     part_div;
        logic     dot_step;
        logic     total_add;
        logic     total_pct;
        logic     set_sign;
        logic     out_load;
        logic     out_consumed;
        logic     out_done;
        logic     out_found;
        len_sel_t len_sel;
    } nlp_cmd_t;

    typedef struct packed {
        logic in_first;
        logic in_pct;
        logic is_digit;
        logic is_space;
        logic is_dot;
        logic is_caret;
        logic is_sign;
        logic sign_seen;
        logic div_busy;
    } nlp_stat_t;

endpackage

`default_nettype wire

>>> rtl/core/nlp_dp.sv
// ----------------------------------------------------------------------------
// nlp_dp
// Datapath: character register, accumulators, tick divider, result register.
// ----------------------------------------------------------------------------
`default_nettype none

module nlp_dp (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire nlp_pkg::nlp_in_t  char_data,
    input  wire nlp_pkg::nlp_cmd_t cmd,
    output nlp_pkg::nlp_stat_t     stat,
    output nlp_pkg::nlp_out_t      res
);

    logic [7:0]                      ch_reg;
    logic [nlp_pkg::VAL_W-1:0]       default_reg;
    logic [nlp_pkg::VAL_W-1:0]       acc_reg;
    logic [nlp_pkg::VAL_W-1:0]       part_reg;
    logic [nlp_pkg::VAL_W-1:0]       dot_reg;
    logic signed [15:0]              total_reg;
    logic                            neg_reg;
    logic                            sgn_reg;
    logic [nlp_pkg::DIV_W-1:0]       dvs_reg;
    logic [nlp_pkg::DIV_W-1:0]       quo_reg;
    logic [nlp_pkg::DIV_W-1:0]       rem_reg;
    logic [nlp_pkg::CNT_W-1:0]       cnt_reg;
    nlp_pkg::nlp_out_t               res_reg;
    nlp_pkg::nlp_out_t               res_next;

    logic [3:0]                      digit_val;
    logic [18:0]                     acc_wide;
    logic [nlp_pkg::VAL_W-1:0]       acc_sat;
    logic [nlp_pkg::VAL_W-1:0]       ticks_v;
    logic [nlp_pkg::DIV_W-1:0]       dvs_sel;
    logic [nlp_pkg::DIV_W:0]         trial;
    logic [nlp_pkg::DIV_W:0]         diff;
    logic                            ge;
    logic [nlp_pkg::VAL_W-1:0]       dot_half;
    logic [nlp_pkg::VAL_W:0]         dot_sum;
    logic [nlp_pkg::VAL_W:0]         total_sum;
    logic signed [15:0]              pct_total;

    assign stat.in_first  = char_data.first;
    assign stat.in_pct    = (char_data.ch == nlp_pkg::CH_PCT);
    assign stat.is_digit  = ch_reg inside {[nlp_pkg::CH_ZERO:nlp_pkg::CH_NINE]};
    assign stat.is_space  = (ch_reg == nlp_pkg::CH_SPACE)
                          || (ch_reg inside {[nlp_pkg::CH_TAB:nlp_pkg::CH_CR]});
    assign stat.is_dot    = (ch_reg == nlp_pkg::CH_DOT);
    assign stat.is_caret  = (ch_reg == nlp_pkg::CH_CARET);
    assign stat.is_sign   = ch_reg inside {nlp_pkg::CH_PLUS, nlp_pkg::CH_MINUS};
    assign stat.sign_seen = sgn_reg;
    assign stat.div_busy  = (cnt_reg != '0);

    assign digit_val = 4'(ch_reg - nlp_pkg::CH_ZERO);
    assign acc_wide  = 19'({acc_reg, 3'b000}) + 19'({acc_reg, 1'b0}) + 19'(digit_val);
    assign acc_sat   = (acc_wide > 19'(nlp_pkg::SAT_MAX)) ? nlp_pkg::SAT_MAX
                                                          : acc_wide[nlp_pkg::VAL_W-1:0];

    assign ticks_v = nlp_pkg::VAL_W'(nlp_pkg::TICKS_PER_WHOLE);
    assign dvs_sel = ((acc_reg == '0) || (acc_reg > ticks_v))
                   ? nlp_pkg::DIV_W'(nlp_pkg::TICKS_PER_WHOLE)
                   : acc_reg[nlp_pkg::DIV_W-1:0];

    assign trial = {rem_reg, quo_reg[nlp_pkg::DIV_W-1]};
    assign ge    = (trial >= {1'b0, dvs_reg});
    assign diff  = trial - {1'b0, dvs_reg};

    assign dot_half  = dot_reg >> 1;
    assign dot_sum   = {1'b0, part_reg} + {1'b0, dot_half};
    assign total_sum = {1'b0, total_reg[nlp_pkg::VAL_W-1:0]} + {1'b0, part_reg};
    assign pct_total = neg_reg ? -$signed({1'b0, acc_reg}) : $signed({1'b0, acc_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            default_reg <= '0;
            acc_reg     <= '0;
            part_reg    <= '0;
            dot_reg     <= '0;
            total_reg   <= '0;
            neg_reg     <= 1'b0;
            sgn_reg     <= 1'b0;
            cnt_reg     <= '0;
        end
        else
        begin
            if (cmd.load && char_data.first)
            begin
                default_reg <= char_data.default_clocks;
                acc_reg     <= '0;
                part_reg    <= '0;
                dot_reg     <= '0;
                total_reg   <= '0;
                neg_reg     <= 1'b0;
                sgn_reg     <= 1'b0;
            end
            if (cmd.acc_start)
            begin
                acc_reg <= nlp_pkg::VAL_W'(digit_val);
            end
            if (cmd.acc_digit)
            begin
                acc_reg <= acc_sat;
            end
            if (cmd.part_default)
            begin
                part_reg <= default_reg;
                dot_reg  <= default_reg;
            end
            if (cmd.part_div)
            begin
                part_reg <= nlp_pkg::VAL_W'(quo_reg);
                dot_reg  <= nlp_pkg::VAL_W'(quo_reg);
            end
            if (cmd.dot_step)
            begin
                dot_reg  <= dot_half;
                part_reg <= dot_sum[nlp_pkg::VAL_W] ? nlp_pkg::SAT_MAX
                                                    : dot_sum[nlp_pkg::VAL_W-1:0];
            end
            if (cmd.total_add)
            begin
                total_reg <= total_sum[nlp_pkg::VAL_W]
                           ? {1'b0, nlp_pkg::SAT_MAX}
                           : {1'b0, total_sum[nlp_pkg::VAL_W-1:0]};
            end
            if (cmd.total_pct)
            begin
                total_reg <= pct_total;
            end
            if (cmd.set_sign)
            begin
                sgn_reg <= 1'b1;
                neg_reg <= (ch_reg == nlp_pkg::CH_MINUS);
            end
            if (cmd.div_start)
            begin
                cnt_reg <= nlp_pkg::CNT_W'(nlp_pkg::DIV_W);
            end
            else if (cnt_reg != '0)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

    always_comb
    begin
        res_next          = res_reg;
        if (cmd.out_load)
        begin
            res_next.consumed = cmd.out_consumed;
            res_next.done_res = cmd.out_done;
            res_next.relative = cmd.out_done & sgn_reg;
            res_next.found    = cmd.out_found;
            case (cmd.len_sel)
                nlp_pkg::LEN_TOTAL:   res_next.length = total_reg;
                nlp_pkg::LEN_DEFAULT: res_next.length = $signed({1'b0, default_reg});
                default:              res_next.length = '0;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            ch_reg <= char_data.ch;
        end
        if (cmd.div_start)
        begin
            dvs_reg <= dvs_sel;
            quo_reg <= nlp_pkg::DIV_W'(nlp_pkg::TICKS_PER_WHOLE);
            rem_reg <= '0;
        end
        else if (cnt_reg != '0)
        begin
            rem_reg <= ge ? diff[nlp_pkg::DIV_W-1:0] : trial[nlp_pkg::DIV_W-1:0];
            quo_reg <= {quo_reg[nlp_pkg::DIV_W-2:0], ge};
        end
        res_reg <= res_next;
    end

    assign res = res_reg;

endmodule

`default_nettype wire

>>> rtl/core/nlp_ctrl.sv
// ----------------------------------------------------------------------------
// nlp_ctrl
// Controller: field phase, per-character sequencing and handshakes.
// ----------------------------------------------------------------------------
`default_nettype none

module nlp_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               char_valid,
    output logic                    char_stall,
    output logic                    len_valid,
    input  wire logic               len_stall,
    input  wire nlp_pkg::nlp_stat_t stat,
    output nlp_pkg::nlp_cmd_t       cmd
);

    nlp_pkg::seq_t     seq_reg;
    nlp_pkg::seq_t     seq_next;
    nlp_pkg::phase_t   phase_reg;
    nlp_pkg::phase_t   phase_next;
    logic              skip_reg;
    logic              skip_next;
    logic              out_valid_reg;
    logic              out_valid_next;
    logic              out_free;
    logic              fin;

    assign out_free   = !out_valid_reg || !len_stall;
    assign char_stall = (seq_reg != nlp_pkg::S_IDLE);
    assign len_valid  = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seq_reg       <= nlp_pkg::S_IDLE;
            phase_reg     <= nlp_pkg::PH_IDLE;
            skip_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            seq_reg       <= seq_next;
            phase_reg     <= phase_next;
            skip_reg      <= skip_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        cmd        = '0;
        seq_next   = seq_reg;
        phase_next = phase_reg;
        skip_next  = skip_reg;
        fin        = 1'b0;

        case (seq_reg)
            nlp_pkg::S_IDLE:
            begin
                if (char_valid)
                begin
                    cmd.load  = 1'b1;
                    seq_next  = nlp_pkg::S_EVAL;
                    skip_next = stat.in_first && stat.in_pct;
                    if (stat.in_first)
                    begin
                        phase_next = stat.in_pct ? nlp_pkg::PH_PCT_SIGN
                                                 : nlp_pkg::PH_PART_START;
                    end
                end
            end

            nlp_pkg::S_EVAL:
            begin
                if (skip_reg)
                begin
                    if (out_free)
                    begin
                        fin              = 1'b1;
                        cmd.out_consumed = 1'b1;
                        skip_next        = 1'b0;
                    end
                end
                else
                begin
                    case (phase_reg)
                        nlp_pkg::PH_PART_START:
                        begin
                            if (!stat.is_digit)
                            begin
                                cmd.part_default = 1'b1;
                                phase_next       = nlp_pkg::PH_DOTS;
                            end
                            else if (out_free)
                            begin
                                cmd.acc_start    = 1'b1;
                                phase_next       = nlp_pkg::PH_PART_DIGITS;
                                fin              = 1'b1;
                                cmd.out_consumed = 1'b1;
                            end
                        end

                        nlp_pkg::PH_PART_DIGITS:
                        begin
                            if (!stat.is_digit)
                            begin
                                cmd.div_start = 1'b1;
                                seq_next      = nlp_pkg::S_DIV;
                            end
                            else if (out_free)
                            begin
                                cmd.acc_digit    = 1'b1;
                                fin              = 1'b1;
                                cmd.out_consumed = 1'b1;
                            end
                        end

                        nlp_pkg::PH_DOTS:
                        begin
                            if (stat.is_dot)
                            begin
                                if (out_free)
                                begin
                                    cmd.dot_step     = 1'b1;
                                    fin              = 1'b1;
                                    cmd.out_consumed = 1'b1;
                                end
                            end
                            else if (stat.is_caret)
                            begin
                                if (out_free)
                                begin
                                    cmd.total_add    = 1'b1;
                                    phase_next       = nlp_pkg::PH_PART_START;
                                    fin              = 1'b1;
                                    cmd.out_consumed = 1'b1;
                                end
                            end
                            else
                            begin
                                cmd.total_add = 1'b1;
                                phase_next    = nlp_pkg::PH_TRAIL;
                            end
                        end

                        nlp_pkg::PH_TRAIL:
                        begin
                            if (out_free)
                            begin
                                fin = 1'b1;
                                if (stat.is_space)
                                begin
                                    cmd.out_consumed = 1'b1;
                                end
                                else
                                begin
                                    cmd.out_done  = 1'b1;
                                    cmd.out_found = 1'b1;
                                    cmd.len_sel   = nlp_pkg::LEN_TOTAL;
                                    phase_next    = nlp_pkg::PH_IDLE;
                                end
                            end
                        end

                        nlp_pkg::PH_PCT_SIGN:
                        begin
                            if (out_free)
                            begin
                                fin = 1'b1;
                                if (!stat.sign_seen && stat.is_sign)
                                begin
                                    cmd.set_sign     = 1'b1;
                                    cmd.out_consumed = 1'b1;
                                end
                                else if (stat.is_digit)
                                begin
                                    cmd.acc_start    = 1'b1;
                                    phase_next       = nlp_pkg::PH_PCT_DIGITS;
                                    cmd.out_consumed = 1'b1;
                                end
                                else
                                begin
                                    cmd.out_done = 1'b1;
                                    cmd.len_sel  = nlp_pkg::LEN_DEFAULT;
                                    phase_next   = nlp_pkg::PH_IDLE;
                                end
                            end
                        end

                        nlp_pkg::PH_PCT_DIGITS:
                        begin
                            if (!stat.is_digit)
                            begin
                                cmd.total_pct = 1'b1;
                                phase_next    = nlp_pkg::PH_TRAIL;
                            end
                            else if (out_free)
                            begin
                                cmd.acc_digit    = 1'b1;
                                fin              = 1'b1;
                                cmd.out_consumed = 1'b1;
                            end
                        end

                        default:
                        begin
                            phase_next = nlp_pkg::PH_IDLE;
                            if (out_free)
                            begin
                                fin = 1'b1;
                            end
                        end
                    endcase
                end
            end

            nlp_pkg::S_DIV:
            begin
                if (!stat.div_busy)
                begin
                    cmd.part_div = 1'b1;
                    phase_next   = nlp_pkg::PH_DOTS;
                    seq_next     = nlp_pkg::S_EVAL;
                end
            end

            default:
            begin
                seq_next = nlp_pkg::S_IDLE;
            end
        endcase

        if (fin)
        begin
            cmd.out_load = 1'b1;
            seq_next     = nlp_pkg::S_IDLE;
        end

        if (fin)
        begin
            out_valid_next = 1'b1;
        end
        else
        begin
            out_valid_next = out_valid_reg && len_stall;
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/note_length_parser.sv
// ----------------------------------------------------------------------------
// note_length_parser
// Streaming note-length field reader: one character in, one result out.
//
//   channel   direction   payload            handshake
//   char      in          nlp_in_t           char_valid / char_stall
//   len       out         nlp_out_t          len_valid / len_stall
//
// Each character is loaded in its accepting cycle and then evaluated step by
// step until its result is registered; a part that ends its digits in normal
// form also runs the shift-subtract tick divider (DIV_W = 7 at 96 ticks).
// One character is in work at a time; the next one is taken while a result
// waits in the output register.
// Reset is asynchronous, active low, and returns the field phase to idle.
// A stalled result holds the finishing step of the character behind it.
// ----------------------------------------------------------------------------
`default_nettype none

module note_length_parser (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              char_valid,
    output logic                   char_stall,
    input  wire nlp_pkg::nlp_in_t  char_data,
    output logic                   len_valid,
    input  wire logic              len_stall,
    output nlp_pkg::nlp_out_t      len_data
);

    nlp_pkg::nlp_cmd_t  cmd;
    nlp_pkg::nlp_stat_t stat;

    nlp_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .char_valid (char_valid),
        .char_stall (char_stall),
        .len_valid  (len_valid),
        .len_stall  (len_stall),
        .stat       (stat),
        .cmd        (cmd)
    );

    nlp_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .char_data (char_data),
        .cmd       (cmd),
        .stat      (stat),
        .res       (len_data)
    );

endmodule

`default_nettype wire

>>> rtl/core/nlp_checker.sv
// ----------------------------------------------------------------------------
// nlp_port_checker
// Port-level checks of the note length parser, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module nlp_port_checker (
    input wire logic              clk,
    input wire logic              rst_n,
    input wire logic              char_valid,
    input wire logic              char_stall,
    input wire logic              len_valid,
    input wire logic              len_stall,
    input wire nlp_pkg::nlp_out_t len_data
);

    logic both_flags;
    logic open_clear;

    assign both_flags = len_data.consumed && len_data.done_res;
    assign open_clear = (len_data.length == 16'sd0) && !len_data.relative
                      && !len_data.found;

    `NLP_ASSERT_NEXT(a_len_hold, clk, rst_n, len_valid && len_stall, len_valid)
    `NLP_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, char_valid && !char_stall, char_stall)
    `NLP_ASSERT_NOW(a_done_not_consumed, clk, rst_n, len_valid, !both_flags)
    `NLP_ASSERT_NOW(a_open_zero, clk, rst_n, len_valid && !len_data.done_res, open_clear)

endmodule

bind note_length_parser nlp_port_checker u_nlp_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .char_valid (char_valid),
    .char_stall (char_stall),
    .len_valid  (len_valid),
    .len_stall  (len_stall),
    .len_data   (len_data)
);

`default_nettype wire

>>> verif/nlp_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// nlp_checker
// Watches the character and length channels of the note length parser,
// keeps its own copy of the field parse state, predicts the result of every
// accepted character and compares each returned result field by field.
// ----------------------------------------------------------------------------
module nlp_checker (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              char_valid,
    input  logic              char_stall,
    input  nlp_pkg::nlp_in_t  char_data,
    input  logic              len_valid,
    input  logic              len_stall,
    input  nlp_pkg::nlp_out_t len_data,
    output int                fail_count,
    output int                outstanding
);
    import nlp_pkg::*;

    localparam int PRINT_CAP = 40;

    nlp_out_t         awaited_len[$];
    int               result_no   = 0;
    phase_t           fld_phase   = PH_IDLE;
    int unsigned      digits_val  = 0;
    int unsigned      part_ticks  = 0;
    int unsigned      dot_add     = 0;
    int               field_total = 0;
    bit               minus_seen  = 1'b0;
    bit               sign_seen   = 1'b0;
    logic [VAL_W-1:0] dflt_len    = '0;

    initial
    begin
        fail_count  = 0;
        outstanding = 0;
    end

    function automatic bit is_dec(logic [7:0] c);
        return c >= CH_ZERO && c <= CH_NINE;
    endfunction

    function automatic bit is_blank(logic [7:0] c);
        return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
    endfunction

    function automatic int unsigned clip(int unsigned v);
        return (v > SAT_MAX) ? SAT_MAX : v;
    endfunction

    function automatic int unsigned ticks_of(int unsigned v);
        int unsigned d;
        d = (v > TICKS_PER_WHOLE) ? TICKS_PER_WHOLE : v;
        return (d == 0) ? 1 : TICKS_PER_WHOLE / d;
    endfunction

    task automatic report_mismatch(string msg);
        if (fail_count < PRINT_CAP)
            $display("[%0t] length check: %s", $time, msg);
        fail_count++;
    endtask

    task automatic check_field(string name, logic signed [31:0] got,
                               logic signed [31:0] want);
        if (got !== want)
            report_mismatch($sformatf("result %0d %s: got %0d, want %0d",
                                      result_no, name, got, want));
    endtask

    task automatic parse_char(input nlp_in_t t, output nlp_out_t r);
        bit again;
        r     = '0;
        again = 1'b1;
        if (t.first)
        begin
            fld_phase   = PH_PART_START;
            digits_val  = 0;
            part_ticks  = 0;
            dot_add     = 0;
            field_total = 0;
            minus_seen  = 1'b0;
            sign_seen   = 1'b0;
            dflt_len    = t.default_clocks;
            if (t.ch == CH_PCT)
            begin
                fld_phase  = PH_PCT_SIGN;
                r.consumed = 1'b1;
                again      = 1'b0;
            end
        end
        while (again)
        begin
            again = 1'b0;
            case (fld_phase)
                PH_PART_START:
                begin
                    if (is_dec(t.ch))
                    begin
                        digits_val = t.ch - CH_ZERO;
                        fld_phase  = PH_PART_DIGITS;
                        r.consumed = 1'b1;
                    end
                    else
                    begin
                        part_ticks = dflt_len;
                        dot_add    = part_ticks;
                        fld_phase  = PH_DOTS;
                        again      = 1'b1;
                    end
                end
                PH_PART_DIGITS:
                begin
                    if (is_dec(t.ch))
                    begin
                        digits_val = clip(digits_val * 10 + (t.ch - CH_ZERO));
                        r.consumed = 1'b1;
                    end
                    else
                    begin
                        part_ticks = ticks_of(digits_val);
                        dot_add    = part_ticks;
                        fld_phase  = PH_DOTS;
                        again      = 1'b1;
                    end
                end
                PH_DOTS:
                begin
                    if (t.ch == CH_DOT)
                    begin
                        dot_add    = dot_add >> 1;
                        part_ticks = clip(part_ticks + dot_add);
                        r.consumed = 1'b1;
                    end
                    else
                    begin
                        field_total = clip(field_total + part_ticks);
                        if (t.ch == CH_CARET)
                        begin
                            fld_phase  = PH_PART_START;
                            r.consumed = 1'b1;
                        end
                        else
                        begin
                            fld_phase = PH_TRAIL;
                            again     = 1'b1;
                        end
                    end
                end
                PH_TRAIL:
                begin
                    if (is_blank(t.ch))
                        r.consumed = 1'b1;
                    else
                    begin
                        r.done_res = 1'b1;
                        r.length   = field_total[15:0];
                        r.relative = sign_seen;
                        r.found    = 1'b1;
                        fld_phase  = PH_IDLE;
                    end
                end
                PH_PCT_SIGN:
                begin
                    if (!sign_seen && (t.ch == CH_PLUS || t.ch == CH_MINUS))
                    begin
                        sign_seen  = 1'b1;
                        minus_seen = (t.ch == CH_MINUS);
                        r.consumed = 1'b1;
                    end
                    else if (is_dec(t.ch))
                    begin
                        digits_val = t.ch - CH_ZERO;
                        fld_phase  = PH_PCT_DIGITS;
                        r.consumed = 1'b1;
                    end
                    else
                    begin
                        r.done_res = 1'b1;
                        r.length   = {1'b0, dflt_len};
                        r.relative = sign_seen;
                        r.found    = 1'b0;
                        fld_phase  = PH_IDLE;
                    end
                end
                PH_PCT_DIGITS:
                begin
                    if (is_dec(t.ch))
                    begin
                        digits_val = clip(digits_val * 10 + (t.ch - CH_ZERO));
                        r.consumed = 1'b1;
                    end
                    else
                    begin
                        field_total = minus_seen ? -int'(digits_val) : int'(digits_val);
                        fld_phase   = PH_TRAIL;
                        again       = 1'b1;
                    end
                end
                default:
                    fld_phase = PH_IDLE;
            endcase
        end
    endtask

    always @(posedge clk)
    begin : watch
        nlp_out_t want;
        if (rst_n)
        begin
            if (len_valid && !len_stall)
            begin
                if (awaited_len.size() == 0)
                    report_mismatch($sformatf("result %0d arrived with none outstanding",
                                              result_no));
                else
                begin
                    want = awaited_len.pop_front();
                    check_field("consumed", len_data.consumed, want.consumed);
                    check_field("done_res", len_data.done_res, want.done_res);
                    check_field("length", len_data.length, want.length);
                    check_field("relative", len_data.relative, want.relative);
                    check_field("found", len_data.found, want.found);
                end
                result_no++;
            end
            if (char_valid && !char_stall)
            begin
                parse_char(char_data, want);
                awaited_len.push_back(want);
            end
            outstanding <= awaited_len.size();
        end
    end

endmodule

>>> verif/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Drives note-length fields into the parser: a directed set of corner cases,
// then random well-formed fields mixed with noise under several idle and
// stall patterns, and reports the verdict of the length checker.
// ----------------------------------------------------------------------------
module tb;
    import nlp_pkg::*;

    localparam int CYCLE_LIMIT      = 200000;
    localparam int RANDOM_PER_PHASE = 125;
    localparam int DRAIN_CYCLES     = 16;

    logic       clk = 1'b0;
    logic       rst_n;
    logic       char_valid;
    logic       char_stall;
    nlp_in_t    char_data;
    logic       len_valid;
    logic       len_stall;
    nlp_out_t   len_data;
    int         fail_count;
    int         outstanding;
    int         cycle_count = 0;
    int         idle_pct    = 0;
    int         stall_pct   = 0;
    int         sent_chars  = 0;
    logic [7:0] field_buf[$];

    note_length_parser uut (
        .clk,
        .rst_n,
        .char_valid,
        .char_stall,
        .char_data,
        .len_valid,
        .len_stall,
        .len_data
    );

    nlp_checker len_check (
        .clk,
        .rst_n,
        .char_valid,
        .char_stall,
        .char_data,
        .len_valid,
        .len_stall,
        .len_data,
        .fail_count,
        .outstanding
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    always @(posedge clk)
        len_stall <= ($urandom_range(99) < stall_pct);

    task automatic put_char(input logic [7:0] c, input logic f,
                            input logic [VAL_W-1:0] dflt);
        while ($urandom_range(99) < idle_pct)
        begin
            char_valid <= 1'b0;
            @(posedge clk);
        end
        char_valid <= 1'b1;
        char_data  <= {c, f, dflt};
        @(posedge clk);
        while (char_stall)
            @(posedge clk);
        sent_chars++;
    endtask

    task automatic send_field(input logic [VAL_W-1:0] dflt);
        foreach (field_buf[i])
            put_char(field_buf[i], i == 0, (i == 0) ? dflt : VAL_W'($urandom));
        field_buf.delete();
    endtask

    task automatic load_text(input string s);
        for (int i = 0; i < s.len(); i++)
            field_buf.push_back(s[i]);
    endtask

    function automatic logic [7:0] pick_blank();
        int r;
        r = $urandom_range(5);
        return (r == 5) ? CH_SPACE : CH_TAB + 8'(r);
    endfunction

    function automatic logic [7:0] pick_digit();
        return CH_ZERO + 8'($urandom_range(9));
    endfunction

    function automatic logic [7:0] pick_sign();
        return $urandom_range(1) ? CH_PLUS : CH_MINUS;
    endfunction

    task automatic run_phase(input int sender_idle, input int recv_stall);
        int               stop_at;
        int               kind;
        int               digits;
        logic [VAL_W-1:0] dflt;
        idle_pct  = sender_idle;
        stall_pct <= recv_stall;
        stop_at   = sent_chars + RANDOM_PER_PHASE;
        while (sent_chars < stop_at)
        begin
            kind = $urandom_range(99);
            dflt = ($urandom_range(3) == 0) ? VAL_W'($urandom)
                                            : VAL_W'($urandom_range(200));
            if (kind < 92)
            begin
                if (kind < 70)
                begin
                    for (int p = 0; p <= $urandom_range(2); p++)
                    begin
                        if (p > 0)
                            field_buf.push_back(CH_CARET);
                        digits = ($urandom_range(19) == 0) ? 6 : $urandom_range(3);
                        repeat (digits)
                            field_buf.push_back(pick_digit());
                        repeat ($urandom_range(3))
                            field_buf.push_back(CH_DOT);
                    end
                end
                else
                begin
                    field_buf.push_back(CH_PCT);
                    if ($urandom_range(1))
                        field_buf.push_back(pick_sign());
                    if ($urandom_range(7) == 0)
                        field_buf.push_back(pick_sign());
                    digits = ($urandom_range(9) == 0) ? 6 : $urandom_range(4);
                    repeat (digits)
                        field_buf.push_back(pick_digit());
                end
                repeat ($urandom_range(2))
                    field_buf.push_back(pick_blank());
                field_buf.push_back(($urandom_range(3) == 0) ? 8'h00 : 8'($urandom));
                send_field(dflt);
            end
            else
            begin
                repeat ($urandom_range(1, 4))
                    put_char(8'($urandom), $urandom_range(3) == 0, VAL_W'($urandom));
            end
        end
    endtask

    initial
    begin
        rst_n      = 1'b0;
        char_valid = 1'b0;
        char_data  = '0;
        len_stall  = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // no field in progress
        put_char(8'hFF, 1'b0, '0);
        // saturate on join, dot and total
        load_text("^.");
        field_buf.push_back(8'hFF);
        send_field(SAT_MAX);
        // zero digits, trailing space
        load_text("0 x");
        send_field('0);
        // value above the whole-note count
        load_text("97r");
        send_field(VAL_W'(24));
        // negative percent value saturates, end of text
        load_text("%-99999");
        field_buf.push_back(8'h00);
        send_field(VAL_W'(48));
        // second sign counts as missing digits
        load_text("%+-");
        send_field(VAL_W'(12));
        load_text("%+5x");
        send_field(VAL_W'(100));
        // abandon a field with a new start
        load_text("8");
        send_field(VAL_W'(24));
        load_text("%7");
        field_buf.push_back(8'h00);
        send_field(VAL_W'(24));

        run_phase(0, 0);
        run_phase(76, 0);
        run_phase(0, 76);
        run_phase(29, 29);

        char_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
